// ----- src/irpc_pkg.sv -----
// Shared types and constants for the IR raw pulse capture block.
// No dependencies; used by irpc_capture and ir_raw_pulse_capture.
`timescale 1ns / 1ps
`default_nettype none

package irpc_pkg;

    localparam int BUF_DEPTH = 128;
    localparam int TICK_W    = 16;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int CMP_W     = (TICK_W > 16) ? TICK_W : 16;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_RESUME = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    localparam logic [1:0] CFG_GAP_MIN      = 2'd0;
    localparam logic [1:0] CFG_MARK_LEVEL   = 2'd1;
    localparam logic [1:0] CFG_BLINK_ENABLE = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_MARK  = 2'd1,
        PH_SPACE = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       ir_level;
        logic [6:0] read_index;
    } irpc_in_t;

    typedef struct packed {
        logic [1:0]  capture_phase;
        logic        frame_ready;
        logic [7:0]  entry_count;
        logic [15:0] read_width;
        logic        read_valid;
        logic        led_on;
    } irpc_out_t;

    typedef struct packed {
        logic [15:0] gap_min;
        logic        mark_level;
        logic        blink_enable;
    } irpc_cfg_t;

endpackage

`default_nettype wire

// ----- src/irpc_capture.sv -----
// Capture state machine, tick counter and width buffer.
// Depends on irpc_pkg. Buffer read is issued when a word is taken in.
`timescale 1ns / 1ps
`default_nettype none

module irpc_capture (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire irpc_pkg::irpc_cfg_t cfg,
    input  wire logic              issue,
    input  wire irpc_pkg::irpc_in_t  issue_word,
    input  wire logic              proc,
    input  wire irpc_pkg::irpc_in_t  proc_word,
    output irpc_pkg::irpc_out_t      result
);
    import irpc_pkg::*;

    logic [TICK_W-1:0] mem [BUF_DEPTH];

    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              led_reg, led_next;

    logic [TICK_W-1:0] rd_data_reg;
    logic [TICK_W-1:0] byp_data_reg;
    logic              byp_hit_reg;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [TICK_W-1:0] wr_data;
    logic [ADDR_W-1:0] issue_addr;

    logic              is_mark;
    logic [TICK_W-1:0] tick_inc;
    phase_t            phase_eff;
    logic              rd_ok;
    logic [TICK_W-1:0] rd_word;

    assign issue_addr = ADDR_W'(issue_word.read_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            cnt_reg   <= '0;
            led_reg   <= 1'b0;
        end
        else if (proc)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            cnt_reg   <= cnt_next;
            led_reg   <= led_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read at take-in; a write landing on the same edge is caught by the bypass.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg  <= mem[issue_addr];
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
        end
        else if (issue)
        begin
            byp_hit_reg <= wr_en && (wr_addr == issue_addr);
        end
    end

    always_comb
    begin
        is_mark    = (proc_word.ir_level == cfg.mark_level);
        tick_inc   = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + 1'b1;
        phase_eff  = (32'(cnt_reg) >= BUF_DEPTH) ? PH_STOP : phase_reg;
        phase_next = phase_reg;
        tick_next  = tick_reg;
        cnt_next   = cnt_reg;
        led_next   = led_reg;
        wr_en      = 1'b0;
        wr_addr    = ADDR_W'(cnt_reg);
        wr_data    = tick_inc;

        case (proc_word.req_type)
            REQ_TICK:
            begin
                phase_next = phase_eff;
                tick_next  = tick_inc;
                case (phase_eff)
                    PH_IDLE:
                    begin
                        if (is_mark)
                        begin
                            tick_next = '0;
                            if (CMP_W'(tick_inc) >= CMP_W'(cfg.gap_min))
                            begin
                                // gap width goes to entry 0
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                cnt_next   = CNT_W'(1);
                                phase_next = PH_MARK;
                            end
                        end
                    end
                    PH_MARK:
                    begin
                        if (!is_mark)
                        begin
                            wr_en      = (32'(cnt_reg) < BUF_DEPTH);
                            cnt_next   = wr_en ? cnt_reg + 1'b1 : cnt_reg;
                            tick_next  = '0;
                            phase_next = PH_SPACE;
                        end
                    end
                    PH_SPACE:
                    begin
                        if (is_mark)
                        begin
                            wr_en      = (32'(cnt_reg) < BUF_DEPTH);
                            cnt_next   = wr_en ? cnt_reg + 1'b1 : cnt_reg;
                            tick_next  = '0;
                            phase_next = PH_MARK;
                        end
                        else if (CMP_W'(tick_inc) > CMP_W'(cfg.gap_min))
                        begin
                            phase_next = PH_STOP;
                        end
                    end
                    default:
                    begin
                        if (is_mark)
                        begin
                            tick_next = '0;
                        end
                    end
                endcase
                if (cfg.blink_enable)
                begin
                    led_next = is_mark;
                end
                wr_en = wr_en && proc;
            end
            REQ_RESUME:
            begin
                phase_next = PH_IDLE;
                cnt_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rd_ok   = (proc_word.req_type == REQ_READ)
                  && (32'(proc_word.read_index) < 32'(cnt_reg))
                  && (32'(proc_word.read_index) < BUF_DEPTH);
        rd_word = byp_hit_reg ? byp_data_reg : rd_data_reg;

        result.capture_phase = phase_next;
        result.frame_ready   = (phase_next == PH_STOP) && (cnt_next != '0);
        result.entry_count   = 8'(cnt_next);
        result.read_width    = rd_ok ? 16'(rd_word) : 16'd0;
        result.read_valid    = rd_ok;
        result.led_on        = led_next;
    end

endmodule

`default_nettype wire

// ----- src/ir_raw_pulse_capture.sv -----
// IR raw pulse capture: config registers, input stage and result register.
// Depends on irpc_pkg and irpc_capture.
// Path: a word taken in passes through the input stage and then the result register;
// a stall on the output holds it in the input stage.
// Throughput: one word per cycle while the output is not stalled; the state update and
// buffer write fit in one pass between the input stage and the result register.
// Reset: phase idle, counters and indicator cleared, config at defaults;
// buffer contents are not cleared and are only readable once written.
`timescale 1ns / 1ps
`default_nettype none

module ir_raw_pulse_capture (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire irpc_pkg::irpc_in_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output irpc_pkg::irpc_out_t      out_data
);
    import irpc_pkg::*;

    irpc_cfg_t cfg_reg;
    logic      s1_valid_reg;
    irpc_in_t  s1_data_reg;
    logic      out_valid_reg;
    irpc_out_t out_data_reg;
    irpc_out_t result;

    logic out_free;
    logic s1_adv;
    logic in_fire;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap_min      <= 16'd100;
            cfg_reg.mark_level   <= 1'b0;
            cfg_reg.blink_enable <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_GAP_MIN:      cfg_reg.gap_min      <= cfg_data;
                CFG_MARK_LEVEL:   cfg_reg.mark_level   <= cfg_data[0];
                CFG_BLINK_ENABLE: cfg_reg.blink_enable <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_adv)
        begin
            out_data_reg <= result;
        end
    end

    irpc_capture u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .issue      (in_fire),
        .issue_word (in_data),
        .proc       (s1_adv),
        .proc_word  (s1_data_reg),
        .result     (result)
    );

endmodule

`default_nettype wire

// ----- tb/ir_raw_pulse_capture_tb.sv -----
// Self-checking testbench for ir_raw_pulse_capture: directed and random word streams
// are checked against a predictor of the capture machine.
// Depends on irpc_pkg and the ir_raw_pulse_capture RTL.
`timescale 1ns / 1ps

module ir_raw_pulse_capture_tb;

    import irpc_pkg::*;

    localparam logic [1:0] REQ_SPARE = 2'd3;  // unused request code

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_GAP_MIN;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    irpc_in_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    irpc_out_t   out_data;

    ir_raw_pulse_capture DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state and its copy of the config registers
    phase_t            cap_phase = PH_IDLE;
    logic [TICK_W-1:0] ticks = '0;
    int                n_entries = 0;
    logic [TICK_W-1:0] widths [BUF_DEPTH];
    logic              led = 1'b0;
    logic [15:0]       gap_thr = 16'd100;
    logic              mark_lvl = 1'b0;
    logic              blink_en = 1'b0;

    irpc_out_t   due_status [$];
    int          errors = 0;
    int          words_sent = 0;
    int          status_checked = 0;
    int          frames_seen = 0;
    int          configs_used = 0;
    int          burst_left = 0;
    bit          steady = 1'b0;
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_left = 0;

    function automatic void record_width();
        if (n_entries < BUF_DEPTH)
        begin
            widths[n_entries] = ticks;
            n_entries++;
        end
    endfunction

    // advances the predictor by one word and returns the status it should produce
    function automatic irpc_out_t capture_step(irpc_in_t w);
        irpc_out_t r;
        logic      is_mark;
        r = '0;
        case (w.req_type)
            REQ_TICK:
            begin
                is_mark = (w.ir_level == mark_lvl);
                if (ticks != TICK_MAX)
                    ticks = ticks + 1'b1;
                if (n_entries >= BUF_DEPTH)
                    cap_phase = PH_STOP;
                case (cap_phase)
                    PH_IDLE:
                        if (is_mark)
                        begin
                            if (ticks < gap_thr)
                                ticks = '0;
                            else
                            begin
                                n_entries = 0;
                                record_width();
                                ticks = '0;
                                cap_phase = PH_MARK;
                            end
                        end
                    PH_MARK:
                        if (!is_mark)
                        begin
                            record_width();
                            ticks = '0;
                            cap_phase = PH_SPACE;
                        end
                    PH_SPACE:
                        if (is_mark)
                        begin
                            record_width();
                            ticks = '0;
                            cap_phase = PH_MARK;
                        end
                        else if (ticks > gap_thr)
                            cap_phase = PH_STOP;
                    default:
                        if (is_mark)
                            ticks = '0;
                endcase
                if (blink_en)
                    led = is_mark;
            end
            REQ_RESUME:
            begin
                cap_phase = PH_IDLE;
                n_entries = 0;
            end
            REQ_READ:
                if (w.read_index < n_entries)
                begin
                    r.read_valid = 1'b1;
                    r.read_width = widths[w.read_index][15:0];
                end
            default: ;
        endcase
        r.capture_phase = cap_phase;
        r.frame_ready   = (cap_phase == PH_STOP) && (n_entries != 0);
        r.entry_count   = n_entries[7:0];
        r.led_on        = led;
        return r;
    endfunction

    function automatic irpc_in_t make_word(logic [1:0] req, logic level, logic [6:0] idx);
        irpc_in_t w;
        w.req_type   = req;
        w.ir_level   = level;
        w.read_index = idx;
        return w;
    endfunction

    function automatic irpc_in_t tick_word(logic is_mark);
        return make_word(REQ_TICK, is_mark ? mark_lvl : ~mark_lvl, 7'($urandom_range(0, 127)));
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want_v);
        if (errors < 40)
            $display("MISMATCH at status %0d: %s got %0h expected %0h",
                     status_checked, what, got, want_v);
        errors++;
    endtask

    // one word, held until the block takes it
    task automatic send_word(irpc_in_t w);
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        due_status.push_back(capture_step(w));
        words_sent++;
    endtask

    // sender in bursts with random gaps between them, unless steady is set
    task automatic push_word(irpc_in_t w);
        int gap;
        if (!steady && burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 40);
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        send_word(w);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (due_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_GAP_MIN:      gap_thr  = value;
            CFG_MARK_LEVEL:   mark_lvl = value[0];
            CFG_BLINK_ENABLE: blink_en = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] gap, logic mark, logic blink);
        write_reg(CFG_GAP_MIN, gap);
        write_reg(CFG_MARK_LEVEL, {15'd0, mark});
        write_reg(CFG_BLINK_ENABLE, {15'd0, blink});
        configs_used++;
    endtask

    // receiver stall pattern: switches between randomly chosen modes
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(16, 160);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
            default:      out_stall <= ~out_stall;
        endcase
    end

    always @(posedge clk)
    begin
        irpc_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_status.size() == 0)
                report("status word with none expected", 32'(out_data), '0);
            else
            begin
                want = due_status.pop_front();
                if (out_data.capture_phase !== want.capture_phase)
                    report("capture_phase", 32'(out_data.capture_phase),
                           32'(want.capture_phase));
                if (out_data.frame_ready !== want.frame_ready)
                    report("frame_ready", 32'(out_data.frame_ready), 32'(want.frame_ready));
                if (out_data.entry_count !== want.entry_count)
                    report("entry_count", 32'(out_data.entry_count), 32'(want.entry_count));
                if (out_data.read_width !== want.read_width)
                    report("read_width", 32'(out_data.read_width), 32'(want.read_width));
                if (out_data.read_valid !== want.read_valid)
                    report("read_valid", 32'(out_data.read_valid), 32'(want.read_valid));
                if (out_data.led_on !== want.led_on)
                    report("led_on", 32'(out_data.led_on), 32'(want.led_on));
                if (want.frame_ready)
                    frames_seen++;
            end
            status_checked++;
        end
    end

    // empty buffer reads, spare code, short gap, one frame ending on a long space
    task automatic test_directed();
        push_word(make_word(REQ_READ, 1'b0, 7'd0));
        push_word(make_word(REQ_READ, 1'b1, 7'd127));
        push_word(make_word(REQ_SPARE, 1'b1, 7'h55));
        push_word(make_word(REQ_RESUME, 1'b0, 7'h2A));
        wait_idle();
        set_config(16'd2, 1'b0, 1'b1);
        push_word(tick_word(1'b1));          // gap too short: counter cleared
        repeat (2) push_word(tick_word(1'b0));
        push_word(tick_word(1'b1));          // gap of 3 recorded
        push_word(tick_word(1'b1));
        push_word(tick_word(1'b0));          // mark of 2 recorded
        repeat (3) push_word(tick_word(1'b0)); // space runs past the gap: stop
        push_word(tick_word(1'b0));
        push_word(tick_word(1'b1));          // mark while stopped clears the counter
        push_word(make_word(REQ_READ, 1'b0, 7'd0));
        push_word(make_word(REQ_READ, 1'b1, 7'd1));
        push_word(make_word(REQ_READ, 1'b0, 7'd2));
        push_word(make_word(REQ_RESUME, 1'b1, 7'h7F));
        push_word(make_word(REQ_READ, 1'b1, 7'd0));
    endtask

    task automatic test_full_buffer();
        wait_idle();
        set_config(16'd1, 1'b1, 1'b0);
        push_word(make_word(REQ_RESUME, 1'b0, 7'd0));
        repeat (2) push_word(tick_word(1'b0));
        for (int i = 0; i < 70; i++)
        begin
            push_word(tick_word(1'b1));
            push_word(tick_word(1'b0));
        end
        push_word(tick_word(1'b1));
        push_word(make_word(REQ_READ, 1'b1, 7'd127));
        push_word(make_word(REQ_READ, 1'b0, 7'd0));
        push_word(make_word(REQ_RESUME, 1'b1, 7'd3));
    endtask

    // gap, a train of marks and spaces, a few reads, usually a resume
    task automatic send_frame();
        int gap_len;
        int pulses;
        gap_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, gap_thr)
                                              : gap_thr + $urandom_range(0, 3);
        repeat (gap_len) push_word(tick_word(1'b0));
        pulses = $urandom_range(1, 8);
        for (int i = 0; i < pulses; i++)
        begin
            repeat ($urandom_range(1, 4)) push_word(tick_word(1'b1));
            repeat ($urandom_range(1, gap_thr + 3)) push_word(tick_word(1'b0));
        end
        repeat ($urandom_range(1, 3))
            push_word(make_word(REQ_READ, 1'($urandom_range(0, 1)),
                                7'($urandom_range(0, 2 * pulses + 1))));
        if ($urandom_range(0, 9) < 7)
            push_word(make_word(REQ_RESUME, 1'($urandom_range(0, 1)),
                                7'($urandom_range(0, 127))));
    endtask

    task automatic test_random_frames();
        int start;
        int pick;
        for (int p = 0; p < 6; p++)
        begin
            wait_idle();
            case (p)
                0: set_config(16'd0, 1'b1, 1'b1);
                1: set_config(16'd1, 1'b0, 1'b0);
                default: set_config(16'($urandom_range(0, 6)), 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)));
            endcase
            steady = (p == 3);
            start = words_sent;
            while (words_sent - start < 185)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_frame();
                else if (pick < 85)
                    repeat ($urandom_range(1, 6))
                        push_word(make_word(REQ_TICK, 1'($urandom_range(0, 1)),
                                            7'($urandom_range(0, 127))));
                else if (pick < 95)
                    push_word(make_word(REQ_READ, 1'($urandom_range(0, 1)),
                                        7'($urandom_range(0, 127))));
                else
                    push_word(make_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                        7'($urandom_range(0, 127))));
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_buffer();
        test_random_frames();
        wait_idle();
        repeat (10) @(posedge clk);
        $display("Sent %0d words over %0d register settings; checked %0d status words.",
                 words_sent, configs_used, status_checked);
        $display("Status words showing a stopped frame: %0d.", frames_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout: %0d status words still expected", due_status.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
src/irpc_pkg.sv
src/irpc_capture.sv
src/ir_raw_pulse_capture.sv
tb/ir_raw_pulse_capture_tb.sv
